@@ src/wrlm_pkg.sv @@
package wrlm_pkg;

	// Widths of the configuration registers.
	localparam int WIN_LEN_W = 13;
	localparam int LONG_W    = 5;
	localparam int FRAME_W   = 8;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;

	// Divisor width: window length times windows per long level.
	localparam int DEN_W = WIN_LEN_W + LONG_W;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOWS_PER_LONG  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOWS_PER_FRAME = 2'd2;

	// Register values after reset.
	localparam logic [WIN_LEN_W-1:0] RST_WINDOW_LEN        = 13'd200;
	localparam logic [LONG_W-1:0]    RST_WINDOWS_PER_LONG  = 5'd10;
	localparam logic [FRAME_W-1:0]   RST_WINDOWS_PER_FRAME = 8'd80;

	// Default values of the top-level parameters.
	localparam int DEF_MAX_WINDOW_LEN   = 4096;
	localparam int DEF_MAX_LONG_WINDOWS = 16;
	localparam int DEF_SAMPLE_BITS      = 16;

	// Sequencer of the meter.
	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_SQR   = 8'b0000_0010,
		ST_ACC   = 8'b0000_0100,
		ST_CLOSE = 8'b0000_1000,
		ST_DIVS  = 8'b0001_0000,
		ST_EMITS = 8'b0010_0000,
		ST_DIVL  = 8'b0100_0000,
		ST_EMITL = 8'b1000_0000
	} meter_state_t;

	// Sequencer of the serial divide and square-root unit.
	typedef enum logic [2:0] {
		DS_IDLE = 3'b001,
		DS_DIV  = 3'b010,
		DS_SQRT = 3'b100
	} ds_state_t;

	// Status of the divide and square-root unit.
	typedef struct packed {
		logic busy;
		logic done;
	} ds_stat_t;

endpackage

@@ src/wrlm_ifs.sv @@
// Sample channel: one audio sample per request.
interface wrlm_sample_if import wrlm_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// Level channel: one short or long level per request.
interface wrlm_level_if import wrlm_pkg::*; #(
	parameter int LEVEL_BITS = DEF_SAMPLE_BITS
) ();
	logic                  valid;
	logic                  ready;
	logic [LEVEL_BITS-1:0] level;
	logic                  is_long;
	logic [LEVEL_BITS-1:0] frame_max;
	logic [LEVEL_BITS-1:0] frame_min;
	logic                  frame_end;
	logic                  last;

	modport source (output valid, output level, output is_long, output frame_max,
		output frame_min, output frame_end, output last, input ready);
	modport sink (input valid, input level, input is_long, input frame_max,
		input frame_min, input frame_end, input last, output ready);
endinterface

@@ src/wrlm_divsqrt.sv @@
// Serial unit: restoring division one quotient bit per cycle, followed by
// a digit-by-digit square root of the quotient, one root bit per cycle.
module wrlm_divsqrt import wrlm_pkg::*; #(
	parameter int NUM_W = 47,
	parameter int DN_W  = DEN_W
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [NUM_W-1:0]           num,
	input  logic [DN_W-1:0]            den,
	output logic [(NUM_W+1)/2-1:0]     root,
	output ds_stat_t                   stat
);

	localparam int RT_W  = (NUM_W + 1) / 2;
	localparam int OP_W  = 2 * RT_W;
	localparam int CNT_W = $clog2(NUM_W + 1);

	ds_state_t        state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	logic [DN_W-1:0]  rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DN_W-1:0]  den_q;
	logic [RT_W:0]    srem_q;
	logic [RT_W-1:0]  root_q;
	logic [OP_W-1:0]  sop_q;

	logic [DN_W:0]    div_sh;
	logic             div_ge;
	logic [DN_W-1:0]  div_rem;
	logic [NUM_W-1:0] quo_next;
	logic [RT_W+2:0]  sq_sh;
	logic [RT_W+2:0]  sq_trial;
	logic             sq_ge;
	logic [RT_W:0]    sq_rem;

	// One restoring division step.
	always_comb begin
		div_sh   = {rem_q, quo_q[NUM_W-1]};
		div_ge   = div_sh >= {1'b0, den_q};
		div_rem  = div_ge ? DN_W'(div_sh - {1'b0, den_q}) : div_sh[DN_W-1:0];
		quo_next = {quo_q[NUM_W-2:0], div_ge};
	end

	// One square-root step: bring down two bits, try root*4+1.
	always_comb begin
		sq_sh    = {srem_q, sop_q[OP_W-1 -: 2]};
		sq_trial = {1'b0, root_q, 2'b01};
		sq_ge    = sq_sh >= sq_trial;
		sq_rem   = sq_ge ? (RT_W+1)'(sq_sh - sq_trial) : sq_sh[RT_W:0];
	end

	// Step sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DS_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				DS_IDLE: begin
					if (start) begin
						cnt_q   <= '0;
						state_q <= DS_DIV;
					end
				end
				DS_DIV: begin
					if (cnt_q == CNT_W'(NUM_W - 1)) begin
						cnt_q   <= '0;
						state_q <= DS_SQRT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				DS_SQRT: begin
					if (cnt_q == CNT_W'(RT_W - 1)) begin
						cnt_q   <= '0;
						done_q  <= 1'b1;
						state_q <= DS_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= DS_IDLE;
				end
			endcase
		end
	end

	// Datapath shift registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			DS_IDLE: begin
				if (start) begin
					quo_q <= num;
					den_q <= den;
					rem_q <= '0;
				end
			end
			DS_DIV: begin
				rem_q <= div_rem;
				quo_q <= quo_next;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					sop_q  <= OP_W'(quo_next);
					srem_q <= '0;
					root_q <= '0;
				end
			end
			DS_SQRT: begin
				srem_q <= sq_rem;
				root_q <= {root_q[RT_W-2:0], sq_ge};
				sop_q  <= {sop_q[OP_W-3:0], 2'b00};
			end
			default: begin
			end
		endcase
	end

	assign root      = root_q;
	assign stat.busy = state_q != DS_IDLE;
	assign stat.done = done_q;

endmodule

@@ src/windowed_rms_level_meter_core.sv @@
// Channel   Dir   Handshake      Payload
// samples   in    valid/ready    sample (signed, SAMPLE_BITS)
// levels    out   valid/ready    level, is_long, frame_max, frame_min, frame_end, last
// cfg       in    cfg_we         cfg_idx, cfg_data (no read-back)
//
// A sample goes through accept, a bit-serial square and the accumulate. A sample that
// closes a window then gets its short level, and a long level follows when one is due;
// the one shared serial divide and square-root unit computes both levels.
// Reset is asynchronous, active low; it restores the register defaults and clears all sums,
// counters and frame trackers. A stalled level request waits in the output register while
// the next sample is taken; the block waits only when it must load a new level into a full
// output register.
module windowed_rms_level_meter_core import wrlm_pkg::*; #(
	parameter int MAX_WINDOW_LEN   = DEF_MAX_WINDOW_LEN,
	parameter int MAX_LONG_WINDOWS = DEF_MAX_LONG_WINDOWS,
	parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	wrlm_sample_if.sink          samples,
	wrlm_level_if.source         levels,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int SB     = SAMPLE_BITS;
	localparam int SQ_W   = 2 * SB - 1;
	localparam int SS_W   = SQ_W + $clog2(MAX_WINDOW_LEN);
	localparam int LS_W   = SS_W + $clog2(MAX_LONG_WINDOWS);
	localparam int RT_W   = (LS_W + 1) / 2;
	localparam int SQC_W  = $clog2(SB + 1);
	localparam logic [RT_W-1:0] MIN_RST = RT_W'(1) << (SB - 1);

	// Configuration registers.
	logic [WIN_LEN_W-1:0] wl_q;
	logic [LONG_W-1:0]    wpl_q;
	logic [FRAME_W-1:0]   wpf_q;

	// Control and accumulation state.
	meter_state_t         state_q;
	logic [SQC_W-1:0]     sq_cnt_q;
	logic [SS_W-1:0]      short_sum_q;
	logic [LS_W-1:0]      long_sum_q;
	logic [WIN_LEN_W-1:0] count_q;
	logic [LONG_W-1:0]    lwc_q;
	logic [FRAME_W-1:0]   fwc_q;
	logic [RT_W-1:0]      max_q;
	logic [RT_W-1:0]      min_q;
	logic                 long_due_q;
	logic                 out_valid_q;

	// Payload registers.
	logic [SB:0]          sq_hi_q;
	logic [SB-1:0]        sq_lo_q;
	logic [SB-1:0]        mcand_q;
	logic [DEN_W-1:0]     long_div_q;
	logic [RT_W-1:0]      lvl_q;
	logic [SB-1:0]        hold_max_q;
	logic [SB-1:0]        hold_min_q;
	logic [SB-1:0]        out_level_q;
	logic                 out_is_long_q;
	logic [SB-1:0]        out_max_q;
	logic [SB-1:0]        out_min_q;
	logic                 out_fend_q;
	logic                 out_last_q;

	// Combinational helpers.
	logic [WIN_LEN_W-1:0] wl_eff;
	logic [LONG_W-1:0]    wpl_eff;
	logic [FRAME_W-1:0]   wpf_eff;
	logic [SB-1:0]        raw;
	logic [SB-1:0]        mag;
	logic [SB:0]          sq_sum;
	logic [2*SB:0]        sq_prod;
	logic [SS_W-1:0]      ss_new;
	logic [WIN_LEN_W:0]   cnt_new;
	logic                 win_close;
	logic [LONG_W:0]      lwc_new;
	logic                 long_due;
	logic [RT_W-1:0]      new_max;
	logic [RT_W-1:0]      new_min;
	logic [FRAME_W:0]     fwc_new;
	logic                 fend;
	logic                 out_free;
	logic                 out_load_s;
	logic                 out_load_l;
	logic                 ds_start;
	logic [LS_W-1:0]      ds_num;
	logic [DEN_W-1:0]     ds_den;
	logic [RT_W-1:0]      ds_root;
	ds_stat_t             ds_stat;

	// Register values as used: zero acts as one; a too large window length or long count clamps.
	always_comb begin
		if (wl_q == '0) begin
			wl_eff = WIN_LEN_W'(1);
		end else if (32'(wl_q) > 32'(MAX_WINDOW_LEN)) begin
			wl_eff = WIN_LEN_W'(MAX_WINDOW_LEN);
		end else begin
			wl_eff = wl_q;
		end
		if (wpl_q == '0) begin
			wpl_eff = LONG_W'(1);
		end else if (32'(wpl_q) > 32'(MAX_LONG_WINDOWS)) begin
			wpl_eff = LONG_W'(MAX_LONG_WINDOWS);
		end else begin
			wpl_eff = wpl_q;
		end
		wpf_eff = (wpf_q == '0) ? FRAME_W'(1) : wpf_q;
	end

	// Sample magnitude; the most negative sample maps to 2^(SB-1).
	assign raw = samples.sample;
	assign mag = raw[SB-1] ? (~raw + 1'b1) : raw;

	// Shift-and-add square, one multiplier bit per cycle.
	assign sq_sum  = sq_lo_q[0] ? (sq_hi_q + (SB+1)'(mcand_q)) : sq_hi_q;
	assign sq_prod = {sq_hi_q, sq_lo_q};

	// Window accumulate and close test.
	always_comb begin
		ss_new    = short_sum_q + SS_W'(sq_prod[SQ_W-1:0]);
		cnt_new   = (WIN_LEN_W+1)'(count_q) + 1'b1;
		win_close = cnt_new >= (WIN_LEN_W+1)'(wl_eff);
		lwc_new   = (LONG_W+1)'(lwc_q) + 1'b1;
		long_due  = lwc_new >= (LONG_W+1)'(wpl_eff);
	end

	// Frame trackers with the new short level included.
	always_comb begin
		new_max = (lvl_q > max_q) ? lvl_q : max_q;
		new_min = (lvl_q < min_q) ? lvl_q : min_q;
		fwc_new = (FRAME_W+1)'(fwc_q) + 1'b1;
		fend    = fwc_new >= (FRAME_W+1)'(wpf_eff);
	end

	// Output register loads and divide unit requests.
	always_comb begin
		out_free   = !out_valid_q || levels.ready;
		out_load_s = (state_q == ST_EMITS) && out_free;
		out_load_l = (state_q == ST_EMITL) && out_free;
		ds_start   = (state_q == ST_CLOSE) || (out_load_s && long_due_q);
		ds_num     = (state_q == ST_CLOSE) ? LS_W'(short_sum_q) : long_sum_q;
		ds_den     = (state_q == ST_CLOSE) ? DEN_W'(wl_eff) : long_div_q;
	end

	wrlm_divsqrt #(
		.NUM_W (LS_W),
		.DN_W  (DEN_W)
	) u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ds_start),
		.num    (ds_num),
		.den    (ds_den),
		.root   (ds_root),
		.stat   (ds_stat)
	);

	// Sequencer, counters, sums, trackers and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q        <= RST_WINDOW_LEN;
			wpl_q       <= RST_WINDOWS_PER_LONG;
			wpf_q       <= RST_WINDOWS_PER_FRAME;
			state_q     <= ST_IDLE;
			sq_cnt_q    <= '0;
			short_sum_q <= '0;
			long_sum_q  <= '0;
			count_q     <= '0;
			lwc_q       <= '0;
			fwc_q       <= '0;
			max_q       <= '0;
			min_q       <= MIN_RST;
			long_due_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_WINDOW_LEN:        wl_q  <= cfg_data[WIN_LEN_W-1:0];
					CFG_WINDOWS_PER_LONG:  wpl_q <= cfg_data[LONG_W-1:0];
					CFG_WINDOWS_PER_FRAME: wpf_q <= cfg_data[FRAME_W-1:0];
					default: begin
					end
				endcase
			end

			if (out_load_s || out_load_l) begin
				out_valid_q <= 1'b1;
			end else if (levels.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (samples.valid) begin
						sq_cnt_q <= '0;
						state_q  <= ST_SQR;
					end
				end
				ST_SQR: begin
					if (sq_cnt_q == SQC_W'(SB - 1)) begin
						state_q <= ST_ACC;
					end else begin
						sq_cnt_q <= sq_cnt_q + 1'b1;
					end
				end
				ST_ACC: begin
					short_sum_q <= ss_new;
					if (win_close) begin
						count_q    <= '0;
						long_due_q <= long_due;
						lwc_q      <= long_due ? '0 : lwc_new[LONG_W-1:0];
						state_q    <= ST_CLOSE;
					end else begin
						count_q <= cnt_new[WIN_LEN_W-1:0];
						state_q <= ST_IDLE;
					end
				end
				ST_CLOSE: begin
					long_sum_q  <= long_sum_q + LS_W'(short_sum_q);
					short_sum_q <= '0;
					state_q     <= ST_DIVS;
				end
				ST_DIVS: begin
					if (ds_stat.done) begin
						state_q <= ST_EMITS;
					end
				end
				ST_EMITS: begin
					if (out_free) begin
						max_q <= fend ? '0 : new_max;
						min_q <= fend ? MIN_RST : new_min;
						fwc_q <= fend ? '0 : fwc_new[FRAME_W-1:0];
						if (long_due_q) begin
							long_sum_q <= '0;
							state_q    <= ST_DIVL;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_DIVL: begin
					if (ds_stat.done) begin
						state_q <= ST_EMITL;
					end
				end
				ST_EMITL: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: square, divisor, levels and output payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && samples.valid) begin
			sq_hi_q <= '0;
			sq_lo_q <= mag;
			mcand_q <= mag;
		end else if (state_q == ST_SQR) begin
			{sq_hi_q, sq_lo_q} <= {sq_sum, sq_lo_q} >> 1;
		end
		if (state_q == ST_CLOSE) begin
			long_div_q <= DEN_W'(DEN_W'(wl_eff) * DEN_W'(wpl_eff));
		end
		if (ds_stat.done) begin
			lvl_q <= ds_root;
		end
		if (out_load_s) begin
			out_level_q   <= lvl_q[SB-1:0];
			out_is_long_q <= 1'b0;
			out_max_q     <= new_max[SB-1:0];
			out_min_q     <= new_min[SB-1:0];
			out_fend_q    <= fend;
			out_last_q    <= !long_due_q;
			hold_max_q    <= new_max[SB-1:0];
			hold_min_q    <= new_min[SB-1:0];
		end else if (out_load_l) begin
			out_level_q   <= lvl_q[SB-1:0];
			out_is_long_q <= 1'b1;
			out_max_q     <= hold_max_q;
			out_min_q     <= hold_min_q;
			out_fend_q    <= 1'b0;
			out_last_q    <= 1'b1;
		end
	end

	// Channel outputs.
	assign samples.ready    = state_q == ST_IDLE;
	assign levels.valid     = out_valid_q;
	assign levels.level     = out_level_q;
	assign levels.is_long   = out_is_long_q;
	assign levels.frame_max = out_max_q;
	assign levels.frame_min = out_min_q;
	assign levels.frame_end = out_fend_q;
	assign levels.last      = out_last_q;

	// A long level always follows a short level that was not the last one.
	a_long_after_short: assert property (@(posedge clk) disable iff (!arst_n)
		out_load_l |-> !out_last_q)
		else $error("long level loaded after a short level marked last");

	// No sample is taken while the divide unit is still at work.
	a_idle_unit: assert property (@(posedge clk) disable iff (!arst_n)
		samples.ready |-> !ds_stat.busy)
		else $error("sample request accepted while divide unit busy");

	// The divide unit finishes only while the sequencer waits for it.
	a_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		ds_stat.done |-> (state_q == ST_DIVS || state_q == ST_DIVL))
		else $error("divide unit finished outside a wait state");

	// A new level request appears only after an emit state.
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMITS || state_q == ST_EMITL))
		else $error("level request raised outside an emit state");

endmodule

@@ tb/sv/testbench.sv @@
module testbench import wrlm_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN_CAP       = DEF_MAX_WINDOW_LEN;
	localparam int LONG_CAP      = DEF_MAX_LONG_WINDOWS;
	localparam int FRAME_CAP     = 255;
	localparam int DRAIN_CYCLES  = 200;
	localparam int STALL_LIMIT   = 20000;
	localparam int PRINT_LIMIT   = 40;
	localparam int N_PHASES      = 16;
	localparam int PHASE_ITEMS   = 60;
	localparam int BIG_WIN_ITEMS = 600;

	// Index that decodes to no register.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	// How a directed row is handled: register write, or a sample with a given
	// kind of expectation.
	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_NONE,
		ROW_PAIR,
		ROW_MODEL
	} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_W-1:0]      data;
		logic signed [15:0]    smp;
		logic [15:0]           lvl;
	} row_t;

	typedef struct packed {
		logic [15:0] level;
		logic        is_long;
		logic [15:0] fmax;
		logic [15:0] fmin;
		logic        fend;
		logic        last;
	} level_rec_t;

	localparam int N_ROWS = 32;

	// Directed stimulus. A pair row expects a short and a long level that both
	// equal lvl, which holds with one-sample windows, long periods and frames.
	row_t rows [N_ROWS] = '{
		'{ROW_NONE,  CFG_WINDOW_LEN,        13'd0, 16'sd0,      16'd0},
		'{ROW_NONE,  CFG_WINDOW_LEN,        13'd0, 16'sh8000,   16'd0},
		'{ROW_NONE,  CFG_WINDOW_LEN,        13'd0, 16'sd300,    16'd0},
		'{ROW_CFG,   CFG_WINDOW_LEN,        13'd1, 16'sd0,      16'd0},
		'{ROW_CFG,   CFG_WINDOWS_PER_LONG,  13'd1, 16'sd0,      16'd0},
		'{ROW_CFG,   CFG_WINDOWS_PER_FRAME, 13'd1, 16'sd0,      16'd0},
		'{ROW_MODEL, CFG_WINDOW_LEN,        13'd0, 16'sd100,    16'd0},
		'{ROW_PAIR,  CFG_WINDOW_LEN,        13'd0, 16'sh8000,   16'd32768},
		'{ROW_PAIR,  CFG_WINDOW_LEN,        13'd0, 16'sd32767,  16'd32767},
		'{ROW_PAIR,  CFG_WINDOW_LEN,        13'd0, 16'sd0,      16'd0},
		'{ROW_PAIR,  CFG_WINDOW_LEN,        13'd0, 16'sd1,      16'd1},
		'{ROW_PAIR,  CFG_WINDOW_LEN,        13'd0, -16'sd1,     16'd1},
		'{ROW_PAIR,  CFG_WINDOW_LEN,        13'd0, -16'sd32767, 16'd32767},
		'{ROW_PAIR,  CFG_WINDOW_LEN,        13'd0, 16'sd16384,  16'd16384},
		'{ROW_PAIR,  CFG_WINDOW_LEN,        13'd0, -16'sd2,     16'd2},
		'{ROW_CFG,   CFG_WINDOW_LEN,        13'd0, 16'sd0,      16'd0},
		'{ROW_CFG,   CFG_WINDOWS_PER_LONG,  13'd0, 16'sd0,      16'd0},
		'{ROW_CFG,   CFG_WINDOWS_PER_FRAME, 13'd0, 16'sd0,      16'd0},
		'{ROW_PAIR,  CFG_WINDOW_LEN,        13'd0, -16'sd5,     16'd5},
		'{ROW_CFG,   CFG_SPARE,             13'd6, 16'sd0,      16'd0},
		'{ROW_PAIR,  CFG_WINDOW_LEN,        13'd0, 16'sd181,    16'd181},
		'{ROW_CFG,   CFG_WINDOW_LEN,        13'd2, 16'sd0,      16'd0},
		'{ROW_CFG,   CFG_WINDOWS_PER_LONG,  13'd3, 16'sd0,      16'd0},
		'{ROW_CFG,   CFG_WINDOWS_PER_FRAME, 13'd2, 16'sd0,      16'd0},
		'{ROW_MODEL, CFG_WINDOW_LEN,        13'd0, 16'sd300,    16'd0},
		'{ROW_MODEL, CFG_WINDOW_LEN,        13'd0, -16'sd300,   16'd0},
		'{ROW_MODEL, CFG_WINDOW_LEN,        13'd0, 16'sd32767,  16'd0},
		'{ROW_MODEL, CFG_WINDOW_LEN,        13'd0, 16'sh8000,   16'd0},
		'{ROW_MODEL, CFG_WINDOW_LEN,        13'd0, 16'sd7,      16'd0},
		'{ROW_MODEL, CFG_WINDOW_LEN,        13'd0, 16'sd0,      16'd0},
		'{ROW_MODEL, CFG_WINDOW_LEN,        13'd0, -16'sd1234,  16'd0},
		'{ROW_MODEL, CFG_WINDOW_LEN,        13'd0, 16'sd4321,   16'd0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_data;

	wrlm_sample_if #(.SAMPLE_BITS(DEF_SAMPLE_BITS)) sample_ch ();
	wrlm_level_if #(.LEVEL_BITS(DEF_SAMPLE_BITS)) level_ch ();

	windowed_rms_level_meter_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (sample_ch),
		.levels   (level_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// Meter state as the predictor sees it.
	logic [WIN_LEN_W-1:0] win_len_reg   = RST_WINDOW_LEN;
	logic [LONG_W-1:0]    long_reg      = RST_WINDOWS_PER_LONG;
	logic [FRAME_W-1:0]   frame_reg     = RST_WINDOWS_PER_FRAME;
	longint unsigned      window_energy = 0;
	longint unsigned      long_energy   = 0;
	longint unsigned      samples_in_win = 0;
	longint unsigned      wins_in_long  = 0;
	longint unsigned      wins_in_frame = 0;
	longint unsigned      frame_hi      = 0;
	longint unsigned      frame_lo      = 32768;

	level_rec_t levels_due [$];
	int         errors = 0;
	int         src_idle_pct = 0;
	int         snk_idle_pct = 0;
	int         quiet_cycles = 0;

	always #10 clk = ~clk;

	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	function automatic longint unsigned clamp_count(longint unsigned v, longint unsigned hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Advance the meter by one sample and return the levels it produces.
	task automatic meter_step(input logic signed [15:0] smp, output level_rec_t short_lvl,
		output level_rec_t long_lvl, output int n);
		longint unsigned wl;
		longint unsigned wpl;
		longint unsigned wpf;
		longint unsigned mag;
		longint unsigned lvl;
		longint unsigned llvl;
		int              sv;
		logic            fend;
		wl = clamp_count(win_len_reg, WIN_CAP);
		wpl = clamp_count(long_reg, LONG_CAP);
		wpf = clamp_count(frame_reg, FRAME_CAP);
		sv = smp;
		if (sv < 0)
			sv = -sv;
		mag = sv;
		short_lvl = '0;
		long_lvl = '0;
		n = 0;
		window_energy += mag * mag;
		samples_in_win++;
		if (samples_in_win < wl)
			return;

		// The window closes: short level and frame trackers.
		lvl = floor_root(window_energy / wl);
		long_energy += window_energy;
		window_energy = 0;
		samples_in_win = 0;
		if (lvl > frame_hi)
			frame_hi = lvl;
		if (lvl < frame_lo)
			frame_lo = lvl;
		wins_in_frame++;
		fend = (wins_in_frame >= wpf);
		short_lvl = '{lvl[15:0], 1'b0, frame_hi[15:0], frame_lo[15:0], fend, 1'b1};
		n = 1;

		// The long period may close on the same window.
		wins_in_long++;
		if (wins_in_long >= wpl) begin
			llvl = floor_root(long_energy / (wl * wpl));
			short_lvl.last = 1'b0;
			long_lvl = '{llvl[15:0], 1'b1, short_lvl.fmax, short_lvl.fmin, 1'b0, 1'b1};
			n = 2;
			long_energy = 0;
			wins_in_long = 0;
		end
		if (fend) begin
			wins_in_frame = 0;
			frame_hi = 0;
			frame_lo = 32768;
		end
	endtask

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= PRINT_LIMIT)
			$display("%0t mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	// Offer one sample request, wait for it to be taken, and record the levels due.
	task automatic send_sample(input logic signed [15:0] smp, input row_kind_t kind,
		input logic [15:0] lvl);
		level_rec_t short_lvl;
		level_rec_t long_lvl;
		int         n;
		while ($urandom_range(99) < src_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample <= smp;
		do @(posedge clk); while (!sample_ch.ready);
		meter_step(smp, short_lvl, long_lvl, n);
		if (kind == ROW_PAIR) begin
			levels_due.push_back('{lvl, 1'b0, lvl, lvl, 1'b1, 1'b0});
			levels_due.push_back('{lvl, 1'b1, lvl, lvl, 1'b0, 1'b1});
		end else if (kind == ROW_MODEL) begin
			if (n > 0)
				levels_due.push_back(short_lvl);
			if (n > 1)
				levels_due.push_back(long_lvl);
		end
	endtask

	// Stop offering samples and let the meter run dry.
	task automatic settle();
		sample_ch.valid <= 1'b0;
		while (levels_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_WINDOW_LEN:        win_len_reg = data[WIN_LEN_W-1:0];
			CFG_WINDOWS_PER_LONG:  long_reg = data[LONG_W-1:0];
			CFG_WINDOWS_PER_FRAME: frame_reg = data[FRAME_W-1:0];
			default: ;
		endcase
	endtask

	// Mix of full-scale, small and arbitrary samples.
	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(7))
			0: begin
				case ($urandom_range(4))
					0: return 16'sh8000;
					1: return 16'sd32767;
					2: return 16'sd0;
					3: return -16'sd1;
					default: return 16'sd1;
				endcase
			end
			1, 2: return 16'($signed($urandom_range(600)) - 300);
			default: return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	// Level receiver with random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			level_ch.ready <= 1'b0;
		else
			level_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// Compare each level request with the oldest one due.
	always @(posedge clk) begin
		level_rec_t want;
		if (arst_n && level_ch.valid && level_ch.ready) begin
			if (levels_due.size() == 0) begin
				report_mismatch($sformatf("level %0d arrived with none due", level_ch.level));
			end else begin
				want = levels_due.pop_front();
				check_field("level", level_ch.level, want.level);
				check_field("is_long", 16'(level_ch.is_long), 16'(want.is_long));
				check_field("frame_max", level_ch.frame_max, want.fmax);
				check_field("frame_min", level_ch.frame_min, want.fmin);
				check_field("frame_end", 16'(level_ch.frame_end), 16'(want.fend));
				check_field("last", 16'(level_ch.last), 16'(want.last));
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a request.
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (level_ch.valid && level_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int wl;
		int wpl;
		int wpf;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_WINDOW_LEN;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.sample = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, sender mostly busy and receiver mostly stalled.
		src_idle_pct = 8;
		snk_idle_pct = 86;
		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG) begin
				settle();
				write_reg(rows[i].idx, rows[i].data);
			end else begin
				send_sample(rows[i].smp, rows[i].kind, rows[i].lvl);
			end
		end

		// Random phases, each under its own register setting.
		for (int p = 0; p < N_PHASES; p++) begin
			if (p < N_PHASES * 3 / 8) begin
				src_idle_pct = 8;
				snk_idle_pct = 86;
			end else if (p < N_PHASES * 3 / 4) begin
				src_idle_pct = 86;
				snk_idle_pct = 8;
			end else begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			if (p == 0) begin
				wl = 1;
				wpl = 31;
				wpf = 255;
			end else if (p == 1) begin
				wl = 3;
				wpl = 16;
				wpf = 128;
			end else begin
				wl = ($urandom_range(3) == 0) ? $urandom_range(9, 48) : $urandom_range(8);
				wpl = $urandom_range(31);
				wpf = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(10);
			end
			settle();
			write_reg(CFG_WINDOW_LEN, CFG_W'(wl));
			write_reg(CFG_WINDOWS_PER_LONG, {8'($urandom_range(255)), 5'(wpl)});
			write_reg(CFG_WINDOWS_PER_FRAME, {5'($urandom_range(31)), 8'(wpf)});
			if (p % 2 == 1)
				write_reg(CFG_SPARE, CFG_W'($urandom_range(8191)));
			repeat (PHASE_ITEMS)
				send_sample(pick_sample(), ROW_MODEL, 16'd0);
		end

		// Full scale into a clamped window length, then a shorter length closes
		// the window on the next sample: the largest sums of the run.
		settle();
		write_reg(CFG_WINDOW_LEN, 13'h1FFF);
		write_reg(CFG_WINDOWS_PER_LONG, {8'($urandom_range(255)), 5'd1});
		write_reg(CFG_WINDOWS_PER_FRAME, 13'd0);
		repeat (BIG_WIN_ITEMS)
			send_sample(16'sh8000, ROW_MODEL, 16'd0);
		settle();
		write_reg(CFG_WINDOW_LEN, CFG_W'(BIG_WIN_ITEMS + 1));
		send_sample(16'sh8000, ROW_MODEL, 16'd0);

		settle();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
src/wrlm_pkg.sv
src/wrlm_ifs.sv
src/wrlm_divsqrt.sv
src/windowed_rms_level_meter_core.sv
tb/sv/testbench.sv
